// ===== design/event_fifo_with_backpressure_metrics_assert.svh =====
// Assertion macros shared by the event FIFO RTL.
`ifndef EVENT_FIFO_WITH_BACKPRESSURE_METRICS_ASSERT_SVH
`define EVENT_FIFO_WITH_BACKPRESSURE_METRICS_ASSERT_SVH

`ifndef SYNTHESIS
`define EFBM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("event fifo check failed");
`define EFBM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("event fifo check failed");
`else
`define EFBM_ASSERT(label, clk, rst_n, prop)
`define EFBM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/efbm_pkg.sv =====
// Shared types, codes and helpers of the event FIFO.
package efbm_pkg;

    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 32;
    localparam int OCC_OUT_W  = 5;
    localparam int ENTRY_W    = 3;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 144;
    localparam int M_TUSER_W  = 3;

    localparam logic [OP_W-1:0] OP_PUBLISH = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_FAILURE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BACKPRESSURE = 2'd2;

    localparam logic [1:0] SRC_INVALID = 2'd3;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [1:0] source;
        logic       kind;
    } entry_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
    endfunction

endpackage

// ===== design/efbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module efbm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/event_fifo_with_backpressure_metrics.sv =====
// Event FIFO top level: ring buffer, saturating counters and high-water mark.
// An accepted input updates the state and loads stage one; the RAM's registered
// read then joins the metrics in the output register that drives m_tvalid.
// Throughput: one item per cycle; an item enters each cycle unless the
// result register and the stage behind it are both held by m_tready low.
// Reset (aresetn low, synchronous): pointers, counters, high-water mark and
// valid flags clear; the event RAM keeps its contents and needs no clearing.
module event_fifo_with_backpressure_metrics #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] event_type, [3:2] event_source, [7:4] zero
    input  logic [efbm_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [efbm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] popped_type, [2:1] popped_source, [7:3] occupancy,
    // [39:8] published_count, [71:40] processed_count,
    // [103:72] backpressure_count, [135:104] failure_count,
    // [140:136] high_water, [143:141] zero
    output logic [efbm_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status, [2] event_valid
    output logic [efbm_pkg::M_TUSER_W-1:0] m_tuser
);

    import efbm_pkg::*;

    `include "event_fifo_with_backpressure_metrics_assert.svh"

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;

    // fifo state
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] peak_reg, peak_next;
    cnt_t             pub_reg, pub_next;
    cnt_t             proc_reg, proc_next;
    cnt_t             refused_reg, refused_next;
    cnt_t             failed_reg, failed_next;

    // stage one: metrics snapshot waiting for the RAM read data
    logic                s1_valid_reg;
    logic [STATUS_W-1:0] s1_status_reg;
    logic                s1_pop_reg;
    logic [PTR_W-1:0]    s1_occ_reg;

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [OP_W-1:0]     op;
    logic [1:0]          ev_type;
    logic [1:0]          ev_src;
    logic                arg_bad;
    logic [PTR_W-1:0]    occ;
    logic [PTR_W-1:0]    occ_after;
    logic                full;
    logic                empty;
    logic                do_push;
    logic                do_pop;
    logic [STATUS_W-1:0] status;
    logic                s_fire;
    logic                s1_advance;
    entry_t              wr_entry;
    entry_t              rd_entry;
    entry_t              popped;

    assign op      = s_tuser;
    assign ev_type = s_tdata[1:0];
    assign ev_src  = s_tdata[3:2];
    assign arg_bad = ev_type[1] || (ev_src == SRC_INVALID);

    assign occ   = wr_ptr_reg - rd_ptr_reg;
    assign full  = occ[PTR_W-1];
    assign empty = (occ == '0);

    assign s1_advance = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_fire     = s_tvalid && s_tready;

    always_comb begin
        status       = ST_OK;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        refused_next = refused_reg;
        failed_next  = failed_reg;
        case (op)
            OP_PUBLISH: begin
                if (arg_bad) begin
                    status = ST_INVALID;
                end else if (full) begin
                    status       = ST_BACKPRESSURE;
                    refused_next = sat_inc(refused_reg);
                end else begin
                    do_push = 1'b1;
                end
            end
            OP_CONSUME: begin
                do_pop = !empty;
            end
            OP_FAILURE: begin
                failed_next = sat_inc(failed_reg);
            end
            default: begin
                status = ST_INVALID;
            end
        endcase
    end

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(do_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
    assign pub_next    = do_push ? sat_inc(pub_reg) : pub_reg;
    assign proc_next   = do_pop ? sat_inc(proc_reg) : proc_reg;
    assign occ_after   = occ + PTR_W'(do_push) - PTR_W'(do_pop);
    assign peak_next   = (occ_after > peak_reg) ? occ_after : peak_reg;

    assign wr_entry.kind   = ev_type[0];
    assign wr_entry.source = ev_src;

    efbm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (s_fire && do_push),
        .wr_addr (wr_ptr_reg[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (s_fire && do_pop),
        .rd_addr (rd_ptr_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            peak_reg    <= '0;
            pub_reg     <= '0;
            proc_reg    <= '0;
            refused_reg <= '0;
            failed_reg  <= '0;
        end else if (s_fire) begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            peak_reg    <= peak_next;
            pub_reg     <= pub_next;
            proc_reg    <= proc_next;
            refused_reg <= refused_next;
            failed_reg  <= failed_next;
        end
    end

    // stage one holds the metrics; the counters above already moved on
    logic                s1_load;
    cnt_t                s1_pub_reg, s1_proc_reg, s1_refused_reg, s1_failed_reg;
    logic [PTR_W-1:0]    s1_peak_reg;

    assign s1_load = s_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_status_reg  <= status;
            s1_pop_reg     <= do_pop;
            s1_occ_reg     <= occ_after;
            s1_pub_reg     <= pub_next;
            s1_proc_reg    <= proc_next;
            s1_refused_reg <= refused_next;
            s1_failed_reg  <= failed_next;
            s1_peak_reg    <= peak_next;
        end
    end

    // zero the popped fields when nothing was popped
    assign popped = s1_pop_reg ? rd_entry : '0;

    assign m_tdata_next = {3'b000, OCC_OUT_W'(s1_peak_reg), s1_failed_reg, s1_refused_reg,
                           s1_proc_reg, s1_pub_reg, OCC_OUT_W'(s1_occ_reg),
                           popped.source, popped.kind};
    assign m_tuser_next = {s1_pop_reg, s1_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `EFBM_ASSERT(a_occ_bound, aclk, aresetn, occ <= PTR_W'(DEPTH))
    `EFBM_ASSERT(a_peak_covers_occ, aclk, aresetn, peak_reg >= occ)
    `EFBM_ASSERT(a_empty_pop_holds, aclk, aresetn,
        (s_fire && (op == OP_CONSUME) && empty) |=> $stable(rd_ptr_reg))
    `EFBM_ASSERT(a_s1_held_on_stall, aclk, aresetn,
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_occ_reg)))
    `EFBM_ASSERT_ALWAYS(a_no_accept_in_reset, aclk, !aresetn |=> !m_tvalid)

endmodule
